// File: design/twr_pkg.sv
// Shared types, codes and a helper function for the TFTP write receiver.
package twr_pkg;

    localparam logic [2:0] CMD_WRQ     = 3'd0;
    localparam logic [2:0] CMD_DATA    = 3'd1;
    localparam logic [2:0] CMD_ERROR   = 3'd2;
    localparam logic [2:0] CMD_OTHER   = 3'd3;
    localparam logic [2:0] CMD_TIMEOUT = 3'd4;

    localparam logic [2:0] KIND_ACK   = 3'd0;
    localparam logic [2:0] KIND_OACK  = 3'd1;
    localparam logic [2:0] KIND_ERROR = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    localparam logic [1:0] ERR_PEER       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT    = 2'd2;

    localparam logic CFG_DEFAULT_BLOCK_SIZE = 1'b0;
    localparam logic CFG_MAX_TIMEOUTS       = 1'b1;

    localparam logic [15:0] RESET_BLOCK_SIZE   = 16'd512;
    localparam logic [7:0]  RESET_MAX_TIMEOUTS = 8'd10;
    localparam logic [15:0] MIN_BLOCK_BYTES    = 16'd8;
    localparam logic [15:0] HEADER_BYTES       = 16'd4;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        has_size_option;
        logic [15:0] req_block_size;
        logic [15:0] pkt_block;
        logic [15:0] pkt_bytes;
    } event_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] ack_block;
        logic [15:0] byte_count;
        logic [1:0]  error_reason;
        logic        last;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                count;
    } bundle_t;

    function automatic logic [15:0] clamp_size(input logic [15:0] v, input logic [15:0] max_v);
        logic [15:0] r;
        r = v;
        if (v < MIN_BLOCK_BYTES) begin
            r = MIN_BLOCK_BYTES;
        end else if (v > max_v) begin
            r = max_v;
        end
        return r;
    endfunction

endpackage

// File: design/tftp_write_receiver_top.sv
// Top level of the TFTP write receiver: configuration, input register and wiring.
// An accepted item waits in the input register until the result register can take it,
// is then decided combinationally, and its results are offered from the result register.
// Throughput: one item per cycle while each item gives at most one result and m_ready is
// high; an item with more results holds the result register while they leave one per cycle.
// Reset: synchronous active-low aresetn returns the transfer to idle, block size 512,
// timeout limit 10, and empties the input and result registers.
module tftp_write_receiver_top #(
    parameter int MAX_BLOCK_BYTES = 65464
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic        s_has_size_option,
    input  logic [15:0] s_req_block_size,
    input  logic [15:0] s_pkt_block,
    input  logic [15:0] s_pkt_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_ack_block,
    output logic [15:0] m_byte_count,
    output logic [1:0]  m_error_reason,
    output logic        m_last
);

    logic [15:0] dflt_size_reg;
    logic [7:0]  max_to_reg;
    logic        in_valid_reg;
    twr_pkg::event_t  in_reg;
    twr_pkg::bundle_t bundle;
    twr_pkg::result_t m_res;
    logic ser_ready;
    logic fire;

    assign fire    = in_valid_reg && ser_ready;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_size_reg <= twr_pkg::RESET_BLOCK_SIZE;
            max_to_reg    <= twr_pkg::RESET_MAX_TIMEOUTS;
        end else if (cfg_we) begin
            case (cfg_index)
                twr_pkg::CFG_DEFAULT_BLOCK_SIZE: dflt_size_reg <= cfg_wdata;
                twr_pkg::CFG_MAX_TIMEOUTS:       max_to_reg    <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.cmd             <= s_cmd;
            in_reg.has_size_option <= s_has_size_option;
            in_reg.req_block_size  <= s_req_block_size;
            in_reg.pkt_block       <= s_pkt_block;
            in_reg.pkt_bytes       <= s_pkt_bytes;
        end
    end

    twr_core #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .evt         (in_reg),
        .dflt_size   (dflt_size_reg),
        .max_timeouts(max_to_reg),
        .bundle      (bundle)
    );

    twr_out_ser u_out (
        .aclk   (aclk),
        .aresetn(aresetn),
        .load   (fire),
        .bundle (bundle),
        .ready  (ser_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_res  (m_res)
    );

    assign m_kind         = m_res.kind;
    assign m_ack_block    = m_res.ack_block;
    assign m_byte_count   = m_res.byte_count;
    assign m_error_reason = m_res.error_reason;
    assign m_last         = m_res.last;

endmodule

// File: design/twr_core.sv
// Transfer state registers and the single-pass decision logic for one event.
module twr_core #(
    parameter int MAX_BLOCK_BYTES = 65464
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  twr_pkg::event_t  evt,
    input  logic [15:0]      dflt_size,
    input  logic [7:0]       max_timeouts,
    output twr_pkg::bundle_t bundle
);

    localparam logic [15:0] MAX_SIZE = 16'(MAX_BLOCK_BYTES);

    logic        phase_reg, phase_next;
    logic [15:0] last_block_reg, last_block_next;
    logic [15:0] size_reg, size_next;
    logic [7:0]  to_count_reg, to_count_next;

    logic [15:0] expect_blk;
    logic [15:0] raw_len;
    logic [15:0] len;
    logic [8:0]  to_inc;
    logic [15:0] new_size;
    logic [1:0]  n;
    twr_pkg::result_t [twr_pkg::MAX_RESULTS-1:0] res;

    assign expect_blk = last_block_reg + 16'd1;
    assign raw_len = (evt.pkt_bytes >= twr_pkg::HEADER_BYTES)
                   ? (evt.pkt_bytes - twr_pkg::HEADER_BYTES) : 16'd0;
    assign len = (raw_len > size_reg) ? size_reg : raw_len;
    assign to_inc = {1'b0, to_count_reg} + 9'd1;
    assign new_size = evt.has_size_option
                    ? twr_pkg::clamp_size(evt.req_block_size, MAX_SIZE)
                    : twr_pkg::clamp_size(dflt_size, MAX_SIZE);

    always_comb begin
        phase_next      = phase_reg;
        last_block_next = last_block_reg;
        size_next       = size_reg;
        to_count_next   = to_count_reg;
        res             = '0;
        n               = 2'd0;
        if (!phase_reg) begin
            case (evt.cmd)
                twr_pkg::CMD_WRQ: begin
                    phase_next      = 1'b1;
                    last_block_next = 16'd0;
                    to_count_next   = 8'd0;
                    size_next       = new_size;
                    if (evt.has_size_option) begin
                        res[0].kind       = twr_pkg::KIND_OACK;
                        res[0].byte_count = new_size;
                    end else begin
                        res[0].kind = twr_pkg::KIND_ACK;
                    end
                    res[1].kind = twr_pkg::KIND_ACK;
                    n = 2'd2;
                end
                twr_pkg::CMD_DATA, twr_pkg::CMD_ERROR, twr_pkg::CMD_OTHER: begin
                    res[0].kind         = twr_pkg::KIND_ERROR;
                    res[0].error_reason = twr_pkg::ERR_UNEXPECTED;
                    n = 2'd1;
                end
                default: begin
                end
            endcase
        end else begin
            case (evt.cmd)
                twr_pkg::CMD_TIMEOUT: begin
                    if (to_inc > {1'b0, max_timeouts}) begin
                        phase_next          = 1'b0;
                        to_count_next       = 8'd0;
                        res[0].kind         = twr_pkg::KIND_ERROR;
                        res[0].error_reason = twr_pkg::ERR_TIMEOUT;
                    end else begin
                        to_count_next    = to_inc[7:0];
                        res[0].kind      = twr_pkg::KIND_ACK;
                        res[0].ack_block = last_block_reg;
                    end
                    n = 2'd1;
                end
                twr_pkg::CMD_DATA: begin
                    to_count_next = 8'd0;
                    if (evt.pkt_block != expect_blk) begin
                        if (evt.pkt_block > expect_blk) begin
                            res[0].kind      = twr_pkg::KIND_ACK;
                            res[0].ack_block = last_block_reg;
                            n = 2'd1;
                        end
                    end else begin
                        last_block_next = expect_blk;
                        if (len != 16'd0) begin
                            res[0].kind       = twr_pkg::KIND_WRITE;
                            res[0].byte_count = len;
                            n = 2'd1;
                        end
                        res[n].kind      = twr_pkg::KIND_ACK;
                        res[n].ack_block = expect_blk;
                        n = n + 2'd1;
                        if (len != size_reg) begin
                            phase_next  = 1'b0;
                            res[n].kind = twr_pkg::KIND_DONE;
                            n = n + 2'd1;
                        end
                    end
                end
                twr_pkg::CMD_WRQ, twr_pkg::CMD_ERROR, twr_pkg::CMD_OTHER: begin
                    to_count_next = 8'd0;
                    phase_next    = 1'b0;
                    res[0].kind   = twr_pkg::KIND_ERROR;
                    res[0].error_reason = (evt.cmd == twr_pkg::CMD_ERROR)
                                        ? twr_pkg::ERR_PEER : twr_pkg::ERR_UNEXPECTED;
                    n = 2'd1;
                end
                default: begin
                end
            endcase
        end
        if (n != 2'd0) begin
            res[n - 2'd1].last = 1'b1;
        end
    end

    assign bundle.res   = res;
    assign bundle.count = n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= 1'b0;
            last_block_reg <= 16'd0;
            size_reg       <= twr_pkg::RESET_BLOCK_SIZE;
            to_count_reg   <= 8'd0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            last_block_reg <= last_block_next;
            size_reg       <= size_next;
            to_count_reg   <= to_count_next;
        end
    end

    // An error result always leaves the transfer idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && bundle.count != 2'd0 && bundle.res[0].kind == twr_pkg::KIND_ERROR
        |=> !phase_reg)
        else $error("transfer still active after an error result");

    // The timeout count is zero whenever no transfer is active.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !phase_reg |-> to_count_reg == 8'd0)
        else $error("timeout count left over while idle");

endmodule

// File: design/twr_out_ser.sv
// Result bundle register that hands results out one item per cycle while m_ready is high.
module twr_out_ser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  twr_pkg::bundle_t bundle,
    output logic             ready,
    output logic             m_valid,
    input  logic             m_ready,
    output twr_pkg::result_t m_res
);

    logic [1:0] cnt_reg;
    logic [1:0] idx_reg;
    twr_pkg::result_t [twr_pkg::MAX_RESULTS-1:0] res_reg;
    logic pop;
    logic pop_last;

    assign m_valid  = (cnt_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign pop_last = pop && (idx_reg == cnt_reg - 2'd1);
    assign ready    = !m_valid || pop_last;
    assign m_res    = res_reg[idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (load && ready) begin
            cnt_reg <= bundle.count;
            idx_reg <= 2'd0;
        end else if (pop_last) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (pop) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && ready) begin
            res_reg <= bundle.res;
        end
    end

    // The read index always points inside the held bundle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd0 |-> idx_reg < cnt_reg)
        else $error("result index beyond bundle");

    // Only the final result of a bundle carries the last flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_res.last == (idx_reg == cnt_reg - 2'd1)))
        else $error("last flag misplaced");

endmodule
